// ===== rtl/core/sha256_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared types, constants and round functions for the SHA-256 byte hasher.
// ----------------------------------------------------------------------------
package sha256_pkg;

    localparam int unsigned BlockBytes = 64;
    localparam int unsigned Rounds     = 64;
    localparam int unsigned LenOffset  = 56;
    localparam int unsigned QueueDepth = 2;

    typedef enum logic {
        MODE_ABSORB = 1'b0,
        MODE_FINISH = 1'b1
    } mode_t;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_word_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_upper_mid;
        logic [63:0] digest_lower_mid;
        logic [63:0] digest_low;
    } out_word_t;

    // job handed from the front part to the compression engine
    typedef struct packed {
        logic [511:0] block;
        logic         last;
    } job_t;

    localparam logic [255:0] InitHash = {
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    function automatic logic [31:0] round_k(input logic [5:0] idx);
        logic [31:0] k;
        begin
            case (idx)
                6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf;  6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98;  6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; 6'd63: k = 32'hc67178f2;
                default: k = 32'h0;
            endcase
            return k;
        end
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int unsigned n);
        begin
            return (v >> n) | (v << (32 - n));
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/core/sha256_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_front
// Accepts words, packs bytes into blocks, builds the padding blocks and
// pushes finished blocks into the job queue.
// ----------------------------------------------------------------------------
module sha256_front (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sha256_pkg::in_word_t in_word,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output sha256_pkg::job_t          job,
    output logic                      job_valid,
    input  wire logic                 job_ready
);

    typedef enum logic [1:0] {
        ST_FILL = 2'b01,
        ST_PAD2 = 2'b10
    } fr_state_t;

    fr_state_t    state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [5:0]   fill_reg, fill_next;
    logic [63:0]  bits_reg, bits_next;
    logic [63:0]  len_reg, len_next;
    logic         jv_reg, jv_next;
    sha256_pkg::job_t job_reg, job_next;

    logic         take;
    logic         out_free;
    logic [511:0] padded;
    logic [63:0]  total;

    assign out_free = !jv_reg || job_ready;
    assign in_ready = (state_reg == ST_FILL) && out_free;
    assign take     = in_valid && in_ready;
    assign job      = job_reg;
    assign job_valid = jv_reg;

    // pad the held bytes with the marker and zeros; bytes at or past fill
    always_comb
    begin
        total  = bits_reg + {55'd0, fill_reg, 3'd0};
        padded = buf_reg;
        for (int i = 0; i < 64; i++)
        begin
            if (i[5:0] == fill_reg)
                padded[511 - 8*i -: 8] = 8'h80;
            else if (i[5:0] > fill_reg)
                padded[511 - 8*i -: 8] = 8'h00;
        end
    end

    // byte packing and finish sequencing
    always_comb
    begin
        state_next = state_reg;
        buf_next   = buf_reg;
        fill_next  = fill_reg;
        bits_next  = bits_reg;
        len_next   = len_reg;
        jv_next    = jv_reg && !job_ready;
        job_next   = job_reg;
        case (state_reg)
            ST_FILL:
            begin
                if (take)
                begin
                    if (in_word.mode == sha256_pkg::MODE_ABSORB)
                    begin
                        buf_next[511 - 8*fill_reg -: 8] = in_word.data_byte;
                        fill_next = fill_reg + 6'd1;
                        if (fill_reg == 6'd63)
                        begin
                            job_next.block = buf_next;
                            job_next.last  = 1'b0;
                            jv_next        = 1'b1;
                            bits_next      = bits_reg + 64'd512;
                        end
                    end
                    else
                    begin
                        jv_next   = 1'b1;
                        fill_next = 6'd0;
                        bits_next = 64'd0;
                        if (fill_reg >= 6'(sha256_pkg::LenOffset))
                        begin
                            job_next.block = padded;
                            job_next.last  = 1'b0;
                            len_next       = total;
                            state_next     = ST_PAD2;
                        end
                        else
                        begin
                            job_next.block = {padded[511:64], total};
                            job_next.last  = 1'b1;
                        end
                    end
                end
            end
            ST_PAD2:
            begin
                if (out_free)
                begin
                    job_next.block = {448'd0, len_reg};
                    job_next.last  = 1'b1;
                    jv_next        = 1'b1;
                    state_next     = ST_FILL;
                end
            end
            default: state_next = ST_FILL;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FILL;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            jv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            jv_reg    <= jv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        len_reg <= len_next;
        job_reg <= job_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_queue
// Two-entry block queue between the front part and the compression engine.
// ----------------------------------------------------------------------------
module sha256_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire sha256_pkg::job_t push_job,
    input  wire logic             push_valid,
    output logic                  push_ready,
    output sha256_pkg::job_t      pop_job,
    output logic                  pop_valid,
    input  wire logic             pop_ready
);

    sha256_pkg::job_t mem_reg [sha256_pkg::QueueDepth];
    logic       wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic       push, pop;

    assign push_ready = cnt_reg != 2'd2;
    assign pop_valid  = cnt_reg != 2'd0;
    assign pop_job    = mem_reg[rp_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= push_job;
    end

    // pointers and count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
                wp_reg <= !wp_reg;
            if (pop)
                rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_core
// Compression engine: one round per cycle with a rolling 16-word schedule,
// chaining update, digest output register and reset to the initial hash.
// ----------------------------------------------------------------------------
module sha256_core (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256_pkg::job_t      job,
    input  wire logic                  job_valid,
    output logic                       job_ready,
    output sha256_pkg::out_word_t      out_word,
    output logic                       out_valid,
    input  wire logic                  out_ready
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_ROUND = 3'b010,
        ST_ADD   = 3'b100
    } core_state_t;

    core_state_t  state_reg, state_next;
    logic [255:0] hash_reg, hash_next;
    logic [255:0] work_reg, work_next;
    logic [511:0] sched_reg, sched_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         last_reg, last_next;
    logic         ov_reg, ov_next;
    sha256_pkg::out_word_t ow_reg, ow_next;

    logic [31:0] a, b, c, d, e, f, g, h, w0, w1, w9, w14;
    logic [31:0] t1, t2, s0, s1, wn;
    logic [255:0] sum;

    assign job_ready = (state_reg == ST_IDLE) && (!ov_reg || out_ready);
    assign out_valid = ov_reg;
    assign out_word  = ow_reg;

    // one round datapath and schedule step
    always_comb
    begin
        {a, b, c, d, e, f, g, h} = work_reg;
        w0  = sched_reg[511:480];
        w1  = sched_reg[479:448];
        w9  = sched_reg[223:192];
        w14 = sched_reg[63:32];
        s0  = sha256_pkg::rotr(w1, 7) ^ sha256_pkg::rotr(w1, 18) ^ (w1 >> 3);
        s1  = sha256_pkg::rotr(w14, 17) ^ sha256_pkg::rotr(w14, 19) ^ (w14 >> 10);
        wn  = w0 + s0 + w9 + s1;
        t1  = h + (sha256_pkg::rotr(e, 6) ^ sha256_pkg::rotr(e, 11) ^ sha256_pkg::rotr(e, 25))
              + ((e & f) ^ (~e & g)) + sha256_pkg::round_k(rnd_reg) + w0;
        t2  = (sha256_pkg::rotr(a, 2) ^ sha256_pkg::rotr(a, 13) ^ sha256_pkg::rotr(a, 22))
              + ((a & b) ^ (a & c) ^ (b & c));
        for (int i = 0; i < 8; i++)
            sum[255 - 32*i -: 32] = hash_reg[255 - 32*i -: 32] + work_reg[255 - 32*i -: 32];
    end

    // round sequencer
    always_comb
    begin
        state_next = state_reg;
        hash_next  = hash_reg;
        work_next  = work_reg;
        sched_next = sched_reg;
        rnd_next   = rnd_reg;
        last_next  = last_reg;
        ov_next    = ov_reg && !out_ready;
        ow_next    = ow_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid && job_ready)
                begin
                    work_next  = hash_reg;
                    sched_next = job.block;
                    last_next  = job.last;
                    rnd_next   = 6'd0;
                    state_next = ST_ROUND;
                end
            end
            ST_ROUND:
            begin
                work_next  = {t1 + t2, a, b, c, d + t1, e, f, g};
                sched_next = {sched_reg[479:0], wn};
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'(sha256_pkg::Rounds - 1))
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                state_next = ST_IDLE;
                if (last_reg)
                begin
                    ow_next   = sum;
                    ov_next   = 1'b1;
                    hash_next = sha256_pkg::InitHash;
                end
                else
                    hash_next = sum;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            hash_reg  <= sha256_pkg::InitHash;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            hash_reg  <= hash_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        work_reg  <= work_next;
        sched_reg <= sched_next;
        rnd_reg   <= rnd_next;
        last_reg  <= last_next;
        ow_reg    <= ow_next;
    end

endmodule
`default_nettype wire

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher
// SHA-256 over a byte stream, one word per message byte plus a finish word.
// ----------------------------------------------------------------------------
// Absorb words are taken one per cycle while the block queue has room; every
// 64th byte sends a block to the compression engine, which runs one round per
// cycle and then adds the result into the chaining hash. The two-entry queue
// lets filling of the next block overlap compression, so bytes keep being
// taken while a block is compressed. A finish word sends one padding block,
// or two when 56 or more bytes are held; the digest is registered in the add
// step after the final block's rounds and is held in an output register
// until taken.
module sha256_byte_stream_hasher (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire sha256_pkg::in_word_t  in_word,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    output sha256_pkg::out_word_t      out_word,
    output logic                       out_valid,
    input  wire logic                  out_ready
);

    sha256_pkg::job_t f_job, q_job;
    logic f_valid, f_ready, q_valid, q_ready;

    sha256_front u_front (
        .clk, .rst_n, .in_word, .in_valid, .in_ready,
        .job(f_job), .job_valid(f_valid), .job_ready(f_ready)
    );

    sha256_queue u_queue (
        .clk, .rst_n,
        .push_job(f_job), .push_valid(f_valid), .push_ready(f_ready),
        .pop_job(q_job), .pop_valid(q_valid), .pop_ready(q_ready)
    );

    sha256_core u_core (
        .clk, .rst_n,
        .job(q_job), .job_valid(q_valid), .job_ready(q_ready),
        .out_word, .out_valid, .out_ready
    );

endmodule
`default_nettype wire

// ===== rtl/core/sha256_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sha256_checker
// Port-level checks on the hasher, bound to the top level.
// ----------------------------------------------------------------------------
module sha256_checker (
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire sha256_pkg::in_word_t  in_word,
    input wire logic                  in_valid,
    input wire logic                  in_ready,
    input wire sha256_pkg::out_word_t out_word,
    input wire logic                  out_valid,
    input wire logic                  out_ready
);

    // a stalled digest holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_word))
        else $error("digest changed while stalled");

    // no digest right after reset
    assert property (@(posedge clk) !rst_n |=> !out_valid)
        else $error("digest valid out of reset");

    // a waiting input word holds until taken
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid && $stable(in_word))
        else $error("input word dropped or changed while waiting");

    // handshake outputs always known
    assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({in_ready, out_valid}))
        else $error("unknown handshake output");

endmodule

bind sha256_byte_stream_hasher sha256_checker u_checker (
    .clk, .rst_n, .in_word, .in_valid, .in_ready,
    .out_word, .out_valid, .out_ready
);
`default_nettype wire
